// ===== src/drcp_pkg.sv =====
// Shared types, character codes and record layouts of the delimited record
// coordinate parser. Used by the parser top level and its port checker.
// Depends on nothing.
package drcp_pkg;

  // Width of the internal values, and the fixed width of the result fields.
  localparam int VALUE_BITS = 32;
  localparam int REC_W = 32;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic signed [REC_W-1:0] rec_t;
  typedef logic [2:0] pos_t;
  typedef logic [2:0] layout_code_t;
  typedef logic [7:0] char_t;

  // Position code for a field that a layout does not have.
  localparam pos_t NO_POS = 3'd7;

  // Layout register codes.
  localparam layout_code_t LAYOUT_PLAIN     = 3'd0;
  localparam layout_code_t LAYOUT_CELL      = 3'd1;
  localparam layout_code_t LAYOUT_CELL_EXON = 3'd2;
  localparam layout_code_t LAYOUT_CELL_NAME = 3'd3;
  localparam layout_code_t LAYOUT_NAME_EXON = 3'd4;

  // Character codes.
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  // Magnitude cap and the signed range of a value.
  localparam mag_t MAG_CAP = mag_t'(1) << (VALUE_BITS - 1);
  localparam val_t VAL_MAX = val_t'(MAG_CAP - mag_t'(1));
  localparam val_t VAL_MIN = val_t'(MAG_CAP);

  // Largest accumulator that may take one more digit d without passing the cap.
  localparam mag_t DIGIT_LIMIT [10] = '{
    mag_t'((MAG_CAP - mag_t'(0)) / 10), mag_t'((MAG_CAP - mag_t'(1)) / 10),
    mag_t'((MAG_CAP - mag_t'(2)) / 10), mag_t'((MAG_CAP - mag_t'(3)) / 10),
    mag_t'((MAG_CAP - mag_t'(4)) / 10), mag_t'((MAG_CAP - mag_t'(5)) / 10),
    mag_t'((MAG_CAP - mag_t'(6)) / 10), mag_t'((MAG_CAP - mag_t'(7)) / 10),
    mag_t'((MAG_CAP - mag_t'(8)) / 10), mag_t'((MAG_CAP - mag_t'(9)) / 10)
  };

  // Field positions of one layout.
  typedef struct packed {
    pos_t px;
    pos_t py;
    pos_t pcnt;
    pos_t pexon;
    logic has_cell;
    pos_t plast;
    logic extra_delims;
  } layout_t;

  // Decode the layout register; unused codes behave as the plain layout.
  function automatic layout_t layout_lookup(layout_code_t code);
    layout_t lay;
    case (code)
      LAYOUT_CELL:      lay = '{3'd1, 3'd2, 3'd3, NO_POS, 1'b1, 3'd4, 1'b1};
      LAYOUT_CELL_EXON: lay = '{3'd1, 3'd2, 3'd3, 3'd4, 1'b1, 3'd5, 1'b1};
      LAYOUT_CELL_NAME: lay = '{3'd2, 3'd3, 3'd4, NO_POS, 1'b1, 3'd5, 1'b1};
      LAYOUT_NAME_EXON: lay = '{3'd2, 3'd3, 3'd4, 3'd5, 1'b1, 3'd6, 1'b1};
      default:          lay = '{3'd1, 3'd2, NO_POS, NO_POS, 1'b0, 3'd3, 1'b0};
    endcase
    return lay;
  endfunction

endpackage

// ===== src/delimited_record_coordinate_parser.sv =====
// Delimited record coordinate parser: byte stream in, one item per record out.
// Uses drcp_pkg for layouts, character codes and value types.
// The block takes one byte per clock, every clock, as long as in_stall is low.
// A delimiter byte (tab or newline, plus comma and semicolon in the cell
// layouts) that closes the last field of a record produces one result item in
// the output register on the next clock, carrying the record's x, y, count,
// exon and cell label and the running bounding box including this record.
// All parsing of a byte is done combinationally from the parser state registers;
// the single output register is the only buffer, so in_stall rises only while
// a result waits in it and out_stall is high. The layout register is written
// through the cfg channel, which is always ready; write it only while idle.
// Layout codes 5 to 7 behave as the plain four-field layout.
module delimited_record_coordinate_parser
  import drcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  char_t        in_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output rec_t         rec_x,
  output rec_t         rec_y,
  output rec_t         rec_count,
  output rec_t         rec_exon,
  output rec_t         rec_cell,
  output logic         cell_assigned,
  output rec_t         box_min_x,
  output rec_t         box_max_x,
  output rec_t         box_min_y,
  output rec_t         box_max_y,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  layout_code_t cfg_data
);

  // Number parsing phases.
  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  layout_code_t record_layout;
  pos_t         field_pos, field_pos_next;
  logic [1:0]   number_phase, number_phase_next;
  logic         negative_flag, negative_flag_next;
  mag_t         accumulator, accumulator_next;
  val_t         held_fields [4];
  val_t         held_fields_next [4];
  val_t         minimum_x, minimum_x_next, maximum_x, maximum_x_next;
  val_t         minimum_y, minimum_y_next, maximum_y, maximum_y_next;

  layout_t      lay;
  logic         accept, is_delim, is_blank, is_sign, is_digit, emit;
  logic [3:0]   digit, digit_idx;
  mag_t         acc_step;
  val_t         field_v, cell_v;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  // Character classes for the current byte.
  always_comb begin
    lay       = layout_lookup(record_layout);
    is_delim  = (in_byte == CH_TAB) || (in_byte == CH_NL) ||
                (lay.extra_delims && ((in_byte == CH_COMMA) || (in_byte == CH_SEMI)));
    is_blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_NL) ||
                (in_byte == CH_VT) || (in_byte == CH_FF) || (in_byte == CH_CR);
    is_sign   = (in_byte == CH_MINUS) || (in_byte == CH_PLUS);
    is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    digit     = 4'(in_byte - CH_ZERO);
    digit_idx = is_digit ? digit : 4'd0;
  end

  // One decimal digit into the magnitude, saturating at the cap.
  always_comb begin
    if (accumulator > DIGIT_LIMIT[digit_idx]) begin
      acc_step = MAG_CAP;
    end else begin
      acc_step = (accumulator << 3) + (accumulator << 1) + mag_t'(digit_idx);
    end
  end

  // Signed value of the field that the current delimiter closes.
  always_comb begin
    if (negative_flag) begin
      field_v = val_t'(-accumulator);
    end else if (accumulator >= MAG_CAP) begin
      field_v = VAL_MAX;
    end else begin
      field_v = val_t'(accumulator);
    end
    cell_v = lay.has_cell ? field_v : val_t'(0);
  end

  // Next parser state for an accepted byte.
  always_comb begin
    field_pos_next     = field_pos;
    number_phase_next  = number_phase;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    held_fields_next   = held_fields;
    minimum_x_next     = minimum_x;
    maximum_x_next     = maximum_x;
    minimum_y_next     = minimum_y;
    maximum_y_next     = maximum_y;
    emit               = 1'b0;
    if (accept && is_delim) begin
      number_phase_next  = PH_BLANK;
      negative_flag_next = 1'b0;
      accumulator_next   = '0;
      if (field_pos == lay.px) begin
        held_fields_next[0] = field_v;
        if (field_v < minimum_x) minimum_x_next = field_v;
        if (field_v > maximum_x) maximum_x_next = field_v;
      end
      if (field_pos == lay.py) begin
        held_fields_next[1] = field_v;
        if (field_v < minimum_y) minimum_y_next = field_v;
        if (field_v > maximum_y) maximum_y_next = field_v;
      end
      if (field_pos == lay.pcnt) held_fields_next[2] = field_v;
      if (field_pos == lay.pexon) held_fields_next[3] = field_v;
      if (field_pos < lay.plast) begin
        field_pos_next = field_pos + 3'd1;
      end else begin
        emit = 1'b1;
        field_pos_next = '0;
      end
    end else if (accept) begin
      unique case (number_phase)
        PH_BLANK: begin
          priority if (is_blank) begin
            number_phase_next = PH_BLANK;
          end else if (is_sign) begin
            negative_flag_next = (in_byte == CH_MINUS);
            number_phase_next  = PH_DIGITS;
          end else if (is_digit) begin
            accumulator_next  = acc_step;
            number_phase_next = PH_DIGITS;
          end else begin
            number_phase_next = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            accumulator_next = acc_step;
          end else begin
            number_phase_next = PH_DONE;
          end
        end
        default: begin
          number_phase_next = number_phase;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_layout <= LAYOUT_PLAIN;
      field_pos     <= '0;
      number_phase  <= PH_BLANK;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      for (int i = 0; i < 4; i++) held_fields[i] <= '0;
      minimum_x     <= VAL_MAX;
      maximum_x     <= VAL_MIN;
      minimum_y     <= VAL_MAX;
      maximum_y     <= VAL_MIN;
    end else begin
      if (cfg_valid && cfg_ready) record_layout <= cfg_data;
      field_pos     <= field_pos_next;
      number_phase  <= number_phase_next;
      negative_flag <= negative_flag_next;
      accumulator   <= accumulator_next;
      if (emit) begin
        for (int i = 0; i < 4; i++) held_fields[i] <= '0;
      end else begin
        held_fields <= held_fields_next;
      end
      minimum_x     <= minimum_x_next;
      maximum_x     <= maximum_x_next;
      minimum_y     <= minimum_y_next;
      maximum_y     <= maximum_y_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register, loaded when a record closes.
  always_ff @(posedge clk) begin
    if (emit) begin
      rec_x         <= rec_t'(held_fields_next[0]);
      rec_y         <= rec_t'(held_fields_next[1]);
      rec_count     <= rec_t'(held_fields_next[2]);
      rec_exon      <= rec_t'(held_fields_next[3]);
      rec_cell      <= rec_t'(cell_v);
      cell_assigned <= (cell_v > val_t'(0));
      box_min_x     <= rec_t'(minimum_x_next);
      box_max_x     <= rec_t'(maximum_x_next);
      box_min_y     <= rec_t'(minimum_y_next);
      box_max_y     <= rec_t'(maximum_y_next);
    end
  end

endmodule

// ===== src/drcp_checker.sv =====
// Port checker for the delimited record coordinate parser, bound to its top level.
// Uses drcp_pkg for the port types.
module drcp_checker
  import drcp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input rec_t         rec_x,
  input rec_t         rec_y,
  input rec_t         rec_count,
  input rec_t         rec_exon,
  input rec_t         rec_cell,
  input logic         cell_assigned,
  input rec_t         box_min_x,
  input rec_t         box_max_x,
  input rec_t         box_min_y,
  input rec_t         box_max_y
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(rec_x) && $stable(rec_y) && $stable(rec_count) &&
      $stable(rec_exon) && $stable(rec_cell) && $stable(cell_assigned) &&
      $stable(box_min_x) && $stable(box_max_x) && $stable(box_min_y) &&
      $stable(box_max_y))
    else $error("stalled result item changed");

  // Input is held back only while a result waits on a stalled output.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result item");

  // The cell flag is set exactly when the cell label is positive.
  a_cell_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_assigned == (rec_cell > rec_t'(0)))
    else $error("cell flag disagrees with cell label");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind delimited_record_coordinate_parser drcp_checker u_drcp_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the delimited record coordinate parser.
// It sends byte streams, predicts each record item and compares every result.
// Depends on drcp_pkg and the delimited_record_coordinate_parser top level.
`timescale 1ns / 1ps

module tb;
  import drcp_pkg::*;

  // Layout codes above the named ones decode as the plain layout.
  localparam layout_code_t LAYOUT_SPARE_HI = 3'd7;
  localparam int NO_FIELD = 7;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 420;
  localparam longint MAG_LIMIT = 64'sd2147483648;

  // Where each value sits in a record under one layout.
  typedef struct {
    int x_at;
    int y_at;
    int count_at;
    int exon_at;
    int last_at;
    bit has_label;
    bit comma_splits;
  } field_map_t;

  // One predicted record item.
  typedef struct {
    rec_t x;
    rec_t y;
    rec_t count;
    rec_t exon;
    rec_t label;
    logic assigned;
    rec_t min_x;
    rec_t max_x;
    rec_t min_y;
    rec_t max_y;
  } record_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  char_t in_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rec_t rec_x, rec_y, rec_count, rec_exon, rec_cell;
  logic cell_assigned;
  rec_t box_min_x, box_max_x, box_min_y, box_max_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  layout_code_t cfg_data = '0;

  // Predicted parser state.
  layout_code_t layout_now;
  int field_idx;
  int num_phase;
  bit num_negative;
  longint magnitude;
  longint held_vals [4];
  longint low_x, high_x, low_y, high_y;

  record_t pending_records [$];
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int records_seen = 0;
  int layout_writes = 0;
  int cycle_count = 0;

  delimited_record_coordinate_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rec_x        (rec_x),
    .rec_y        (rec_y),
    .rec_count    (rec_count),
    .rec_exon     (rec_exon),
    .rec_cell     (rec_cell),
    .cell_assigned(cell_assigned),
    .box_min_x    (box_min_x),
    .box_max_x    (box_max_x),
    .box_min_y    (box_min_y),
    .box_max_y    (box_max_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls at random, decided once per falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic field_map_t field_map(layout_code_t code);
    field_map_t m;
    case (code)
      LAYOUT_CELL:      m = '{1, 2, 3, NO_FIELD, 4, 1'b1, 1'b1};
      LAYOUT_CELL_EXON: m = '{1, 2, 3, 4, 5, 1'b1, 1'b1};
      LAYOUT_CELL_NAME: m = '{2, 3, 4, NO_FIELD, 5, 1'b1, 1'b1};
      LAYOUT_NAME_EXON: m = '{2, 3, 4, 5, 6, 1'b1, 1'b1};
      default:          m = '{1, 2, NO_FIELD, NO_FIELD, 3, 1'b0, 1'b0};
    endcase
    return m;
  endfunction

  function automatic void clear_number();
    num_phase = 0;
    num_negative = 1'b0;
    magnitude = 0;
  endfunction

  function automatic void reset_parser_model();
    layout_now = LAYOUT_PLAIN;
    field_idx = 0;
    clear_number();
    foreach (held_vals[i]) held_vals[i] = 0;
    low_x = MAG_LIMIT - 1;
    low_y = MAG_LIMIT - 1;
    high_x = -MAG_LIMIT;
    high_y = -MAG_LIMIT;
  endfunction

  // Advance the predicted parser by one byte; queue a record when one closes.
  function automatic void predict_byte(char_t b);
    field_map_t m;
    bit splits;
    longint d;
    longint v;
    int fp;
    record_t r;
    m = field_map(layout_now);
    splits = (b == CH_TAB) || (b == CH_NL) ||
             (m.comma_splits && (b == CH_COMMA || b == CH_SEMI));
    if (!splits) begin
      // Integer conversion: blanks, optional sign, then digits until a non-digit.
      if (num_phase == 0) begin
        if (b == CH_SPACE || b == CH_VT || b == CH_FF || b == CH_CR) return;
        if (b == CH_MINUS || b == CH_PLUS) begin
          num_negative = (b == CH_MINUS);
          num_phase = 1;
          return;
        end
        num_phase = 1;
      end
      if (num_phase == 1) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          d = longint'(b - CH_ZERO);
          if (magnitude > (MAG_LIMIT - d) / 10) magnitude = MAG_LIMIT;
          else magnitude = magnitude * 10 + d;
        end else begin
          num_phase = 2;
        end
      end
      return;
    end
    // A field closes: saturate its value and file it by position.
    if (num_negative) v = -magnitude;
    else if (magnitude >= MAG_LIMIT) v = MAG_LIMIT - 1;
    else v = magnitude;
    fp = field_idx;
    clear_number();
    if (fp == m.x_at) begin
      held_vals[0] = v;
      if (v < low_x) low_x = v;
      if (v > high_x) high_x = v;
    end
    if (fp == m.y_at) begin
      held_vals[1] = v;
      if (v < low_y) low_y = v;
      if (v > high_y) high_y = v;
    end
    if (fp == m.count_at) held_vals[2] = v;
    if (fp == m.exon_at) held_vals[3] = v;
    if (fp < m.last_at) begin
      field_idx = fp + 1;
      return;
    end
    if (!m.has_label) v = 0;
    r.x = rec_t'(held_vals[0]);
    r.y = rec_t'(held_vals[1]);
    r.count = rec_t'(held_vals[2]);
    r.exon = rec_t'(held_vals[3]);
    r.label = rec_t'(v);
    r.assigned = (v > 0);
    r.min_x = rec_t'(low_x);
    r.max_x = rec_t'(high_x);
    r.min_y = rec_t'(low_y);
    r.max_y = rec_t'(high_y);
    pending_records.push_back(r);
    field_idx = 0;
    foreach (held_vals[i]) held_vals[i] = 0;
  endfunction

  function automatic int field_differs(string name, rec_t want, rec_t got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  // Compare each accepted record item with the oldest prediction.
  always @(posedge clk) begin : check_records
    record_t want;
    if (!rst && out_valid && !out_stall) begin
      records_seen <= records_seen + 1;
      if (pending_records.size() == 0) begin
        $display("%0t: record item arrived with none expected, x %0d y %0d",
                 $time, rec_x, rec_y);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_records.pop_front();
        mismatches <= mismatches
          + field_differs("rec_x", want.x, rec_x)
          + field_differs("rec_y", want.y, rec_y)
          + field_differs("rec_count", want.count, rec_count)
          + field_differs("rec_exon", want.exon, rec_exon)
          + field_differs("rec_cell", want.label, rec_cell)
          + field_differs("cell_assigned", rec_t'(want.assigned), rec_t'(cell_assigned))
          + field_differs("box_min_x", want.min_x, box_min_x)
          + field_differs("box_max_x", want.max_x, box_max_x)
          + field_differs("box_min_y", want.min_y, box_min_y)
          + field_differs("box_max_y", want.max_y, box_max_y);
      end
    end
  end

  // Offer one byte, with random idle cycles first, and wait for acceptance.
  task automatic send_byte(char_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    predict_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]));
  endtask

  // Stop sending and wait until every predicted record has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the layout register while the parser is idle.
  task automatic write_layout(layout_code_t code);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= code;
    do @(posedge clk); while (!cfg_ready);
    layout_now = code;
    layout_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Plain layout: 32-bit extremes, saturation and a non-numeric last field.
  task automatic test_number_extremes();
    send_text("g\t2147483647\t-2147483648\t0\n");
    send_text("g\t99999999999\t-99999999999\tabc\n");
    send_text("g,1\t\t+\t");
  endtask

  // Cell layout: blanks before the sign, blank after a sign, digits then junk.
  task automatic test_blanks_and_signs();
    write_layout(LAYOUT_CELL);
    send_byte(CH_SPACE);
    send_byte(CH_VT);
    send_byte(CH_FF);
    send_byte(CH_CR);
    send_text("+12,- 5;12x3,,7\n");
    send_byte(8'h00);
    send_text("\t-0\t8");
    send_byte(8'hFF);
    send_text("9, 4 2;-3\t");
  endtask

  // One record in each remaining layout, and a spare code.
  task automatic test_each_layout();
    write_layout(LAYOUT_CELL_EXON);
    send_text("g\t-4;6,10\t3\t5\n");
    write_layout(LAYOUT_CELL_NAME);
    send_text("g,n,1,2,3,0\n");
    write_layout(LAYOUT_NAME_EXON);
    send_text("g\tn\t-9\t9\t1\t2\t77\n");
    write_layout(LAYOUT_SPARE_HI);
    send_text("g,2\t3,5\t4\t1\n");
  endtask

  // Layout changed part way through a record; the parse state carries over.
  task automatic test_layout_change_mid_record();
    write_layout(LAYOUT_NAME_EXON);
    send_text("g\tn\t5\t6\t7\t8\t");
    write_layout(LAYOUT_PLAIN);
    send_text("3\n");
    write_layout(LAYOUT_CELL_EXON);
    send_text("g,4,5,6,7,");
    write_layout(LAYOUT_CELL);
    send_text("9;");
  endtask

  // One field of random content: small, full range, overflowing, junk or empty.
  task automatic send_random_field();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_SPACE);
          1: send_byte(CH_VT);
          2: send_byte(CH_FF);
          default: send_byte(CH_CR);
        endcase
      end
    end
    case (kind)
      0: ;
      1: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(char_t'($urandom_range(8'h61, 8'h7A)));
      end
      2, 3, 4, 5: send_text($sformatf("%0d", int'($urandom_range(0, 2000)) - 1000));
      6, 7: send_text($sformatf("%0d", int'($urandom)));
      8: begin
        if ($urandom_range(0, 1)) send_byte(CH_MINUS);
        n = $urandom_range(10, 19);
        repeat (n) send_byte(CH_ZERO + char_t'($urandom_range(0, 9)));
      end
      default: begin
        send_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if ($urandom_range(0, 3) == 0) send_byte(CH_SPACE);
        send_text($sformatf("%0d", $urandom_range(0, 99999)));
        send_byte(char_t'($urandom_range(8'h21, 8'h2F)));
        send_text($sformatf("%0d", $urandom_range(0, 99)));
      end
    endcase
  endtask

  task automatic send_random_delimiter();
    field_map_t m;
    m = field_map(layout_now);
    case ($urandom_range(0, m.comma_splits ? 3 : 1))
      0: send_byte(CH_TAB);
      1: send_byte(CH_NL);
      2: send_byte(CH_COMMA);
      default: send_byte(CH_SEMI);
    endcase
  endtask

  // Mostly well-formed records, with noise bursts and layout changes mixed in.
  task automatic test_random_records(int idle_in, int stall_out, int nbytes);
    int stop_at;
    int n;
    field_map_t m;
    idle_pct = idle_in;
    stall_pct = stall_out;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) write_layout(layout_code_t'($urandom_range(0, 7)));
      if ($urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(char_t'($urandom_range(0, 255)));
      end else begin
        m = field_map(layout_now);
        for (int f = 0; f <= m.last_at; f++) begin
          send_random_field();
          send_random_delimiter();
          if ($urandom_range(0, 49) == 0) begin
            write_layout(layout_code_t'($urandom_range(0, 7)));
            m = field_map(layout_now);
          end
        end
      end
    end
    wait_drained();
  endtask

  // A record left without its closing delimiter produces nothing.
  task automatic test_unterminated_record();
    idle_pct = 0;
    stall_pct = 0;
    write_layout(LAYOUT_PLAIN);
    send_text("g\t5\t6\t7");
  endtask

  initial begin
    reset_parser_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_number_extremes();
    test_blanks_and_signs();
    test_each_layout();
    test_layout_change_mid_record();
    test_random_records(0, 0, RANDOM_BYTES);
    test_random_records(58, 0, RANDOM_BYTES);
    test_random_records(0, 58, RANDOM_BYTES);
    test_random_records(27, 27, RANDOM_BYTES);
    test_unterminated_record();
    wait_drained();

    if (pending_records.size() != 0) begin
      $display("%0t: %0d record items never arrived", $time, pending_records.size());
      mismatches++;
    end
    $display("Sent %0d bytes over %0d layout writes and four idle/stall mixes.",
             bytes_sent, layout_writes);
    $display("Checked %0d record items field by field, %0d differences found.",
             records_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/drcp_pkg.sv
src/delimited_record_coordinate_parser.sv
src/drcp_checker.sv
test/tb.sv
